[hdl/nrag_pkg.sv]
// Package for the nearest resize address generator.
// Types, register indexes, result codes and pipeline constants.
// No dependencies.
`default_nettype none
package nrag_pkg;

  localparam int unsigned MAX_DIM  = 4096;
  localparam int unsigned DIM_W    = $clog2(MAX_DIM + 1);
  localparam int unsigned COORD_W  = 12;
  localparam int unsigned TGT_W    = 14;
  localparam int unsigned OFF_W    = 15;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 15;

  localparam int unsigned A_W      = 16;
  localparam int unsigned M_W      = A_W + 1;
  localparam int unsigned SF_W     = DIM_W + 1;
  localparam int unsigned PROD_W   = M_W + SF_W;
  localparam int unsigned MAG_W    = PROD_W - 1;
  localparam int unsigned DEN_W    = TGT_W + 1;
  localparam int unsigned QW       = DIM_W;

  localparam int unsigned ST_PREP  = 0;
  localparam int unsigned ST_MUL   = 1;
  localparam int unsigned ST_NUM   = 2;
  localparam int unsigned ST_OVF   = 3;
  localparam int unsigned ST_DIV0  = 4;
  localparam int unsigned NSTG     = ST_DIV0 + QW;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_H  = 3'd0,
    REG_SRC_W  = 3'd1,
    REG_TGT_H  = 3'd2,
    REG_TGT_W  = 3'd3,
    REG_ROW_OFF = 3'd4,
    REG_COL_OFF = 3'd5,
    REG_XFORM  = 3'd6,
    REG_WRAP   = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    XF_HALF   = 2'd0,
    XF_ASYM   = 2'd1,
    XF_ALIGN  = 2'd2,
    XF_NONE   = 2'd3
  } xform_e;

  typedef enum logic [1:0] {
    KIND_COPY = 2'd0,
    KIND_FILL = 2'd1,
    KIND_SAME = 2'd2,
    KIND_RSVD = 2'd3
  } fill_kind_e;

  typedef struct packed {
    logic [DIM_W-1:0]        src_h;
    logic [DIM_W-1:0]        src_w;
    logic [TGT_W-1:0]        tgt_h;
    logic [TGT_W-1:0]        tgt_w;
    logic signed [OFF_W-1:0] row_off;
    logic signed [OFF_W-1:0] col_off;
    xform_e                  xform;
    logic                    wrap;
  } cfg_t;

endpackage
`default_nettype wire

[hdl/nrag_ifs.sv]
// Handshake channel interfaces of the nearest resize address generator.
// Depends on nrag_pkg.
`default_nettype none
interface nrag_in_if;
  logic                        valid;
  logic                        ready;
  logic [nrag_pkg::COORD_W-1:0] out_row;
  logic [nrag_pkg::COORD_W-1:0] out_col;
  modport source (output valid, out_row, out_col, input ready);
  modport sink   (input valid, out_row, out_col, output ready);
endinterface

interface nrag_out_if;
  logic                        valid;
  logic                        ready;
  logic [nrag_pkg::COORD_W-1:0] src_row;
  logic [nrag_pkg::COORD_W-1:0] src_col;
  logic [1:0]                  fill_kind;
  modport source (output valid, src_row, src_col, fill_kind, input ready);
  modport sink   (input valid, src_row, src_col, fill_kind, output ready);
endinterface

interface nrag_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [nrag_pkg::CFG_IDX_W-1:0] index;
  logic [nrag_pkg::CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hdl/nrag_cfg.sv]
// Configuration register file; clips and normalizes sizes for the datapath.
// Depends on nrag_pkg and nrag_ifs.
`default_nettype none
module nrag_cfg (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  nrag_cfg_if.sink    cfg_i,
  output nrag_pkg::cfg_t cfg_o
);
  import nrag_pkg::*;

  logic [DIM_W-1:0]        src_h_q, src_w_q;
  logic [TGT_W-1:0]        tgt_h_q, tgt_w_q;
  logic signed [OFF_W-1:0] row_off_q, col_off_q;
  logic [1:0]              xform_q;
  logic                    wrap_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_h_q   <= DIM_W'(1);
      src_w_q   <= DIM_W'(1);
      tgt_h_q   <= TGT_W'(1);
      tgt_w_q   <= TGT_W'(1);
      row_off_q <= '0;
      col_off_q <= '0;
      xform_q   <= XF_HALF;
      wrap_q    <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_SRC_H:   src_h_q   <= cfg_i.data[DIM_W-1:0];
        REG_SRC_W:   src_w_q   <= cfg_i.data[DIM_W-1:0];
        REG_TGT_H:   tgt_h_q   <= cfg_i.data[TGT_W-1:0];
        REG_TGT_W:   tgt_w_q   <= cfg_i.data[TGT_W-1:0];
        REG_ROW_OFF: row_off_q <= cfg_i.data[OFF_W-1:0];
        REG_COL_OFF: col_off_q <= cfg_i.data[OFF_W-1:0];
        REG_XFORM:   xform_q   <= cfg_i.data[1:0];
        REG_WRAP:    wrap_q    <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.src_h   = (src_h_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : src_h_q;
    cfg_o.src_w   = (src_w_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : src_w_q;
    cfg_o.tgt_h   = (tgt_h_q == '0) ? TGT_W'(1) : tgt_h_q;
    cfg_o.tgt_w   = (tgt_w_q == '0) ? TGT_W'(1) : tgt_w_q;
    cfg_o.row_off = row_off_q;
    cfg_o.col_off = col_off_q;
    cfg_o.xform   = xform_e'(xform_q);
    cfg_o.wrap    = wrap_q;
  end

endmodule
`default_nettype wire

[hdl/nrag_axis.sv]
// One axis of the coordinate mapping: offset, scale product, numerator,
// overflow test and a one-bit-per-stage restoring divider. Depends on nrag_pkg.
`default_nettype none
module nrag_axis (
  input  wire logic                          clk_i,
  input  wire logic [nrag_pkg::NSTG-1:0]     en_i,
  input  wire logic [nrag_pkg::COORD_W-1:0]  coord_i,
  input  wire logic signed [nrag_pkg::OFF_W-1:0] off_i,
  input  wire logic [nrag_pkg::DIM_W-1:0]    src_i,
  input  wire logic [nrag_pkg::TGT_W-1:0]    tgt_i,
  input  wire nrag_pkg::xform_e              xform_i,
  output logic [nrag_pkg::COORD_W-1:0]       coord_o,
  output logic [nrag_pkg::QW-1:0]            quo_o,
  output logic                               neg_o,
  output logic                               ovf_o
);
  import nrag_pkg::*;

  logic [COORD_W-1:0] coord_q [NSTG];

  logic signed [A_W-1:0]  a_d;
  logic signed [M_W-1:0]  m_d, m_q;
  logic signed [SF_W-1:0] sf_d, sf_q;
  logic [TGT_W-1:0]       sub_d;
  logic [DEN_W-1:0]       den_d;
  logic [TGT_W-1:0]       sub_q [ST_NUM+1];
  logic [DEN_W-1:0]       den_q [NSTG];

  logic signed [PROD_W-1:0] prod_q, num_d;
  logic [MAG_W-1:0]         mag_q;
  logic                     neg_q [NSTG];
  logic                     ovf_q [NSTG];

  logic [MAG_W-1:0] rem_q [QW+1];
  logic [QW-1:0]    quo_q [QW+1];

  always_comb begin
    a_d   = A_W'($signed({1'b0, coord_i})) + A_W'(off_i);
    m_d   = M_W'(a_d);
    sf_d  = SF_W'({1'b0, src_i});
    sub_d = '0;
    den_d = DEN_W'(tgt_i);
    unique case (xform_i)
      XF_HALF: begin
        m_d   = M_W'(a_d) + M_W'(a_d) + M_W'(1);
        sub_d = tgt_i;
        den_d = {tgt_i, 1'b0};
      end
      XF_ASYM: ;
      XF_ALIGN: begin
        if (tgt_i == TGT_W'(1)) begin
          m_d   = '0;
          den_d = DEN_W'(1);
        end else begin
          den_d = DEN_W'(tgt_i - TGT_W'(1));
        end
        sf_d = (src_i == '0) ? '0 : SF_W'({1'b0, src_i}) - SF_W'(1);
      end
      XF_NONE: begin
        sf_d  = SF_W'(1);
        den_d = DEN_W'(1);
      end
      default: ;
    endcase
  end

  assign num_d = prod_q - PROD_W'($signed({1'b0, sub_q[ST_MUL]}));

  always_ff @(posedge clk_i) begin
    if (en_i[ST_PREP]) begin
      coord_q[ST_PREP] <= coord_i;
      m_q              <= m_d;
      sf_q             <= sf_d;
      sub_q[ST_PREP]   <= sub_d;
      den_q[ST_PREP]   <= den_d;
    end
    if (en_i[ST_MUL]) begin
      coord_q[ST_MUL] <= coord_q[ST_PREP];
      prod_q          <= PROD_W'(m_q) * PROD_W'(sf_q);
      sub_q[ST_MUL]   <= sub_q[ST_PREP];
      den_q[ST_MUL]   <= den_q[ST_PREP];
    end
    if (en_i[ST_NUM]) begin
      coord_q[ST_NUM] <= coord_q[ST_MUL];
      neg_q[ST_NUM]   <= num_d[PROD_W-1];
      mag_q           <= num_d[PROD_W-1] ? MAG_W'(-num_d) : MAG_W'(num_d);
      den_q[ST_NUM]   <= den_q[ST_MUL];
      sub_q[ST_NUM]   <= sub_q[ST_MUL];
    end
    if (en_i[ST_OVF]) begin
      coord_q[ST_OVF] <= coord_q[ST_NUM];
      neg_q[ST_OVF]   <= neg_q[ST_NUM];
      ovf_q[ST_OVF]   <= mag_q >= (MAG_W'(den_q[ST_NUM]) << QW);
      den_q[ST_OVF]   <= den_q[ST_NUM];
      rem_q[0]        <= mag_q;
      quo_q[0]        <= '0;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int unsigned S = ST_DIV0 + j;
    localparam int unsigned B = QW - 1 - j;
    logic [MAG_W-1:0] trial;
    assign trial = MAG_W'(den_q[S-1]) << B;
    always_ff @(posedge clk_i) begin
      if (en_i[S]) begin
        coord_q[S] <= coord_q[S-1];
        neg_q[S]   <= neg_q[S-1];
        ovf_q[S]   <= ovf_q[S-1];
        den_q[S]   <= den_q[S-1];
        if (rem_q[j] >= trial) begin
          rem_q[j+1] <= rem_q[j] - trial;
          quo_q[j+1] <= quo_q[j] | (QW'(1) << B);
        end else begin
          rem_q[j+1] <= rem_q[j];
          quo_q[j+1] <= quo_q[j];
        end
      end
    end
  end

  assign coord_o = coord_q[NSTG-1];
  assign quo_o   = quo_q[QW];
  assign neg_o   = neg_q[NSTG-1];
  assign ovf_o   = ovf_q[NSTG-1] | (sub_q[ST_NUM] == '1 && den_q[NSTG-1] == '0);

endmodule
`default_nettype wire

[hdl/nearest_resize_address_gen_top.sv]
// Nearest-neighbor resize address generator, top level.
// Channels: in_i carries one output pixel coordinate (out_row, out_col) per
// beat; out_o returns one beat per input beat with the source row, source
// column and fill kind (copy mapped pixel, constant fill, copy same position).
// cfg_i writes the eight setup registers by index and is always ready; the
// user must see that it is written only while the block holds no work, since
// the block does not enforce this. Each beat passes 17 datapath stages and
// then the output register. Throughput: one beat per cycle unless the receiver
// stalls; the 13 divider stages of each axis retire one quotient bit each.
// Every stage has its own valid bit; a stage loads whenever it is empty or
// the next one moves, so bubbles collapse and input keeps flowing while a
// finished beat waits on a stalled receiver until the pipe is full.
// Reset empties the pipeline and restores sizes 1, offsets 0, modes 0.
// Depends on nrag_pkg, nrag_ifs, nrag_cfg and nrag_axis.
`default_nettype none
module nearest_resize_address_gen_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  nrag_cfg_if.sink  cfg_i,
  nrag_in_if.sink   in_i,
  nrag_out_if.source out_o
);
  import nrag_pkg::*;

  cfg_t cfg;
  logic [NSTG:0]   en;
  logic [NSTG-1:0] v_q, v_d;
  logic            out_v_q;
  logic [COORD_W-1:0] row_q, col_q;
  logic [1:0]         kind_q;

  logic [COORD_W-1:0] r_coord, c_coord;
  logic [QW-1:0]      r_quo, c_quo;
  logic               r_neg, c_neg, r_ovf, c_ovf;
  logic               r_in, c_in;

  nrag_cfg u_cfg (.clk_i, .rst_ni, .cfg_i, .cfg_o(cfg));

  nrag_axis u_row (
    .clk_i, .en_i(en[NSTG-1:0]), .coord_i(in_i.out_row), .off_i(cfg.row_off),
    .src_i(cfg.src_h), .tgt_i(cfg.tgt_h), .xform_i(cfg.xform),
    .coord_o(r_coord), .quo_o(r_quo), .neg_o(r_neg), .ovf_o(r_ovf)
  );

  nrag_axis u_col (
    .clk_i, .en_i(en[NSTG-1:0]), .coord_i(in_i.out_col), .off_i(cfg.col_off),
    .src_i(cfg.src_w), .tgt_i(cfg.tgt_w), .xform_i(cfg.xform),
    .coord_o(c_coord), .quo_o(c_quo), .neg_o(c_neg), .ovf_o(c_ovf)
  );

  always_comb begin
    en[NSTG] = !out_v_q || out_o.ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_d = {v_q[NSTG-2:0], in_i.valid};
  end

  assign in_i.ready = en[0];

  assign r_in = !r_ovf && (!r_neg || r_quo == '0) && (r_quo < cfg.src_h);
  assign c_in = !c_ovf && (!c_neg || c_quo == '0) && (c_quo < cfg.src_w);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      out_v_q <= 1'b0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (en[k]) begin
          v_q[k] <= v_d[k];
        end
      end
      if (en[NSTG]) begin
        out_v_q <= v_q[NSTG-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NSTG]) begin
      if (r_in && c_in) begin
        row_q  <= r_quo[COORD_W-1:0];
        col_q  <= c_quo[COORD_W-1:0];
        kind_q <= KIND_COPY;
      end else if (!cfg.wrap) begin
        row_q  <= '0;
        col_q  <= '0;
        kind_q <= KIND_FILL;
      end else begin
        row_q  <= r_coord;
        col_q  <= c_coord;
        kind_q <= KIND_SAME;
      end
    end
  end

  assign out_o.valid     = out_v_q;
  assign out_o.src_row   = row_q;
  assign out_o.src_col   = col_q;
  assign out_o.fill_kind = kind_q;

endmodule
`default_nettype wire

[hdl/nrag_checker.sv]
// Port-level checker for the nearest resize address generator, with its bind.
// Depends on nrag_pkg and the top level's interface ports.
`default_nettype none
module nrag_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [nrag_pkg::COORD_W-1:0] src_row,
  input wire logic [nrag_pkg::COORD_W-1:0] src_col,
  input wire logic [1:0] fill_kind
);
  import nrag_pkg::*;

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> fill_kind != KIND_RSVD)
    else $error("reserved fill kind on output beat");

  a_fill_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && fill_kind == KIND_FILL) |-> (src_row == '0 && src_col == '0))
    else $error("fill beat carries nonzero address");

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> out_valid)
    else $error("output beat dropped under stall");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=>
      ($stable(src_row) && $stable(src_col) && $stable(fill_kind)))
    else $error("output beat changed under stall");

endmodule

bind nearest_resize_address_gen_top nrag_checker u_nrag_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .src_row   (out_o.src_row),
  .src_col   (out_o.src_col),
  .fill_kind (out_o.fill_kind)
);
`default_nettype wire
